// ===== sv/eag_pkg.sv =====
// Shared types and constants for the 6502 effective address generator.
package eag_pkg;

    // Addressing modes as they arrive in the mode field of a start request.
    localparam logic [3:0] MODE_IMP = 4'd0;
    localparam logic [3:0] MODE_IMM = 4'd1;
    localparam logic [3:0] MODE_ZP  = 4'd2;
    localparam logic [3:0] MODE_ZPX = 4'd3;
    localparam logic [3:0] MODE_ZPY = 4'd4;
    localparam logic [3:0] MODE_ABS = 4'd5;
    localparam logic [3:0] MODE_ABX = 4'd6;
    localparam logic [3:0] MODE_ABY = 4'd7;
    localparam logic [3:0] MODE_IND = 4'd8;
    localparam logic [3:0] MODE_IZX = 4'd9;
    localparam logic [3:0] MODE_IZY = 4'd10;
    localparam logic [3:0] MODE_REL = 4'd11;

    // Request kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Sequencer phases: which operand or pointer byte is awaited next.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_SECOND = 3'd2;
    localparam logic [2:0] PH_THIRD  = 3'd3;
    localparam logic [2:0] PH_FOURTH = 3'd4;

    localparam logic [15:0] PAGE_MASK = 16'hFF00;
    localparam logic [7:0]  SIGN_BIT  = 8'h80;

    typedef struct packed {
        logic        kind;
        logic [3:0]  mode;
        logic [15:0] pc_start;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  read_byte;
    } eag_item_t;

    typedef struct packed {
        logic        done_res;
        logic [15:0] address;
        logic        page_crossed;
        logic [15:0] next_pc;
        logic        protocol_error;
    } eag_result_t;

    typedef struct packed {
        logic        busy;
        logic [3:0]  mode_held;
        logic [2:0]  phase;
        logic [15:0] pc_held;
        logic [7:0]  x_held;
        logic [7:0]  y_held;
        logic [15:0] operand_word;
        logic [7:0]  pointer_low;
    } eag_state_t;

endpackage

// ===== sv/eag_step.sv =====
// Combinational sequencer step: one request against the held state.
module eag_step (
    input  eag_pkg::eag_item_t   item,
    input  eag_pkg::eag_state_t  st,
    output eag_pkg::eag_state_t  st_next,
    output eag_pkg::eag_result_t res
);
    import eag_pkg::*;

    logic [3:0]  start_mode;
    logic [7:0]  b;
    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [15:0] abs_word;
    logic [15:0] abs_ea;
    logic [7:0]  abs_idx;
    logic [15:0] ptr_base;
    logic [15:0] izy_ea;
    logic [7:0]  zp_ptr;

    assign b          = item.read_byte;
    assign pc1        = st.pc_held + 16'd1;
    assign pc2        = st.pc_held + 16'd2;
    assign start_mode = (item.mode > MODE_REL) ? MODE_IMP : item.mode;
    assign abs_word   = {b, st.operand_word[7:0]};
    assign abs_idx    = (st.mode_held == MODE_ABX) ? st.x_held : st.y_held;
    assign abs_ea     = abs_word + {8'h00, abs_idx};
    assign ptr_base   = {b, st.pointer_low};
    assign izy_ea     = ptr_base + {8'h00, st.y_held};
    assign zp_ptr     = (st.mode_held == MODE_IZX) ? (b + st.x_held) : b;

    always_comb
    begin
        st_next = st;
        res     = '0;
        if (item.kind == KIND_START)
        begin
            if (st.busy)
            begin
                res.protocol_error = 1'b1;
            end
            else if (start_mode == MODE_IMP)
            begin
                res.done_res = 1'b1;
                res.next_pc  = item.pc_start;
            end
            else if (start_mode == MODE_IMM)
            begin
                res.done_res = 1'b1;
                res.address  = item.pc_start;
                res.next_pc  = item.pc_start + 16'd1;
            end
            else
            begin
                st_next.busy         = 1'b1;
                st_next.mode_held    = start_mode;
                st_next.pc_held      = item.pc_start;
                st_next.x_held       = item.index_x;
                st_next.y_held       = item.index_y;
                st_next.operand_word = '0;
                st_next.pointer_low  = '0;
                st_next.phase        = PH_FIRST;
                res.address          = item.pc_start;
            end
        end
        else if (!st.busy)
        begin
            res.protocol_error = 1'b1;
        end
        else
        begin
            // Default: finish. A phase that no mode expects finishes with zeros.
            st_next.busy  = 1'b0;
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            case (st.mode_held) inside
                MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL:
                begin
                    if (st.phase == PH_FIRST)
                    begin
                        res.next_pc = pc1;
                        if (st.mode_held == MODE_ZPX)
                            res.address = {8'h00, b + st.x_held};
                        else if (st.mode_held == MODE_ZPY)
                            res.address = {8'h00, b + st.y_held};
                        else if (st.mode_held == MODE_REL)
                            res.address = {{8{(b & SIGN_BIT) != 8'h00}}, b};
                        else
                            res.address = {8'h00, b};
                    end
                end
                MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND:
                begin
                    if (st.phase == PH_FIRST)
                    begin
                        st_next.busy         = 1'b1;
                        st_next.phase        = PH_SECOND;
                        st_next.operand_word = {8'h00, b};
                        res.done_res         = 1'b0;
                        res.address          = pc1;
                    end
                    else if (st.phase == PH_SECOND)
                    begin
                        st_next.operand_word = abs_word;
                        if (st.mode_held == MODE_IND)
                        begin
                            st_next.busy  = 1'b1;
                            st_next.phase = PH_THIRD;
                            res.done_res  = 1'b0;
                            res.address   = abs_word;
                        end
                        else
                        begin
                            res.next_pc = pc2;
                            if (st.mode_held == MODE_ABS)
                            begin
                                res.address = abs_word;
                            end
                            else
                            begin
                                res.address      = abs_ea;
                                res.page_crossed = (abs_ea & PAGE_MASK) !=
                                                   (abs_word & PAGE_MASK);
                            end
                        end
                    end
                    else if (st.mode_held == MODE_IND && st.phase == PH_THIRD)
                    begin
                        // The high pointer byte comes from the same page,
                        // even when the low byte sits at the page end.
                        st_next.busy        = 1'b1;
                        st_next.phase       = PH_FOURTH;
                        st_next.pointer_low = b;
                        res.done_res        = 1'b0;
                        res.address         = {st.operand_word[15:8],
                                               st.operand_word[7:0] + 8'd1};
                    end
                    else if (st.mode_held == MODE_IND && st.phase == PH_FOURTH)
                    begin
                        res.address = ptr_base;
                        res.next_pc = pc2;
                    end
                end
                MODE_IZX, MODE_IZY:
                begin
                    if (st.phase == PH_FIRST)
                    begin
                        st_next.busy         = 1'b1;
                        st_next.phase        = PH_SECOND;
                        st_next.operand_word = {8'h00, zp_ptr};
                        res.done_res         = 1'b0;
                        res.address          = {8'h00, zp_ptr};
                    end
                    else if (st.phase == PH_SECOND)
                    begin
                        // Pointer high byte wraps within page zero.
                        st_next.busy        = 1'b1;
                        st_next.phase       = PH_THIRD;
                        st_next.pointer_low = b;
                        res.done_res        = 1'b0;
                        res.address         = {8'h00, st.operand_word[7:0] + 8'd1};
                    end
                    else if (st.phase == PH_THIRD)
                    begin
                        res.next_pc = pc1;
                        if (st.mode_held == MODE_IZX)
                        begin
                            res.address = ptr_base;
                        end
                        else
                        begin
                            res.address      = izy_ea;
                            res.page_crossed = (izy_ea & PAGE_MASK) !=
                                               (ptr_base & PAGE_MASK);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/cpu6502_effective_address_generator.sv =====
// Top level of the 6502 effective address generator.
//
// This block walks a 6502 addressing mode one memory byte at a time. A start
// request carries the mode, the PC of the first operand byte and the X and Y
// registers; each following byte request carries the byte read at the last
// address the block asked for. Every request produces exactly one result:
// either the next read address (done_res low) or, with done_res high, the
// effective address, the page-cross flag and the PC after the operands. In
// relative mode the finished address is the sign-extended branch offset.
// Indirect mode keeps the original pointer page-wrap behavior, and zero-page
// pointers wrap within page zero. A start while a computation is open, or a
// byte while idle, is answered with protocol_error and otherwise ignored.
// The block accepts one request per clock while item_stall is low. A request
// is registered at the input; the sequencer step runs on it once the result
// slot is free or being emptied, and the held state and the result register
// are updated together from it. The result register lets a new request be
// taken while a finished result waits; only when both the input stage and
// the result register are full and the result is stalled does item_stall
// rise.
module cpu6502_effective_address_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  eag_pkg::eag_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output eag_pkg::eag_result_t result
);
    import eag_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    eag_item_t   s1_item_reg;
    eag_state_t  state_reg;
    eag_state_t  state_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    eag_result_t result_reg;
    eag_result_t step_res;
    logic        advance;
    logic        take;

    // The step stage fires when it holds a request and the result slot is
    // free or is being emptied in this cycle.
    assign advance = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign take    = item_valid && !item_stall;

    assign item_stall   = s1_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    eag_step u_step (
        .item    (s1_item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    always_comb
    begin
        s1_valid_next = take || (s1_valid_reg && !advance);
        if (advance)
            result_valid_next = 1'b1;
        else
            result_valid_next = result_valid_reg && result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            s1_item_reg <= item;
        if (advance)
            result_reg <= step_res;
    end

endmodule

// ===== tb/cpu6502_effective_address_generator_tb.sv =====
// Self-checking testbench for the 6502 effective address generator.
module cpu6502_effective_address_generator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import eag_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 390;
    // The random part changes its idling pattern every this many requests.
    localparam int SEGMENT_LEN   = 60;
    // Slack waited after the last result has returned.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // Mode codes above MODE_REL are not defined and behave as implied mode.
    localparam logic [3:0] MODE_UNUSED_TOP = 4'd15;

    // Idling patterns for the two channels.
    localparam logic [1:0] PACE_FREE      = 2'd0;
    localparam logic [1:0] PACE_SLOW_SRC  = 2'd1;
    localparam logic [1:0] PACE_SLOW_SINK = 2'd2;
    localparam logic [1:0] PACE_BOTH      = 2'd3;

    // A request waiting to be driven, with the idling pattern it is driven
    // under and whether the sender first waits for all results to return.
    typedef struct packed {
        eag_item_t  req;
        logic [1:0] pace;
        logic       drain;
    } queued_req_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    eag_item_t   item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    eag_result_t result;

    queued_req_t bus_requests[$];
    eag_result_t addr_results_due[$];

    // The sequencer state as the testbench believes it to be.
    eag_state_t  seq_state    = '0;

    logic [1:0]  pace_now     = PACE_FREE;
    logic        req_taken    = 1'b0;
    int          useful_count = 0;
    int          mismatches   = 0;
    int          results_seen = 0;
    int          cycles_run   = 0;

    cpu6502_effective_address_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Percentage of cycles in which one side holds off under a given pattern.
    function automatic int pause_pct(input logic [1:0] pace, input logic sink_side);
        case (pace)
            PACE_SLOW_SRC:  return sink_side ? 0 : 84;
            PACE_SLOW_SINK: return sink_side ? 84 : 0;
            PACE_BOTH:      return 8;
            default:        return 0;
        endcase
    endfunction

    // Text form of a result for the mismatch reports.
    function automatic string show(input eag_result_t r);
        return $sformatf("done=%b addr=%h cross=%b npc=%h err=%b",
                         r.done_res, r.address, r.page_crossed, r.next_pc,
                         r.protocol_error);
    endfunction

    // Bytes are biased toward the values that sit on page and sign boundaries.
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 8'hFF;
        else if (roll < 23)
            return 8'h00;
        else if (roll < 31)
            return 8'h80;
        else if (roll < 36)
            return 8'h7F;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_pc();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 16'hFFFF;
        else if (roll < 12)
            return 16'hFFFE;
        else if (roll < 16)
            return 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Every field random, so the fields a request does not use still toggle.
    function automatic eag_item_t any_item();
        eag_item_t r;
        r.kind      = 1'($urandom_range(0, 1));
        r.mode      = 4'($urandom_range(0, 15));
        r.pc_start  = 16'($urandom_range(0, 65535));
        r.index_x   = 8'($urandom_range(0, 255));
        r.index_y   = 8'($urandom_range(0, 255));
        r.read_byte = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic eag_item_t make_start(input logic [3:0] mode, input logic [15:0] pc,
                                             input logic [7:0] x, input logic [7:0] y);
        eag_item_t r;
        r          = any_item();
        r.kind     = KIND_START;
        r.mode     = mode;
        r.pc_start = pc;
        r.index_x  = x;
        r.index_y  = y;
        return r;
    endfunction

    function automatic eag_item_t make_byte(input logic [7:0] b);
        eag_item_t r;
        r           = any_item();
        r.kind      = KIND_BYTE;
        r.read_byte = b;
        return r;
    endfunction

    // Number of memory bytes a mode asks for before it finishes.
    function automatic int operand_reads(input logic [3:0] mode);
        case (mode) inside
            MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL: return 1;
            MODE_ABS, MODE_ABX, MODE_ABY:          return 2;
            MODE_IZX, MODE_IZY:                    return 3;
            MODE_IND:                              return 4;
            default:                               return 0;
        endcase
    endfunction

    task automatic add_req(input eag_item_t r, input logic [1:0] pace, input logic drain);
        queued_req_t q;
        q.req   = r;
        q.pace  = pace;
        q.drain = drain;
        bus_requests.push_back(q);
    endtask

    // One complete address computation with random operand bytes; now and
    // then a stray start request is slipped in while the block is busy.
    task automatic queue_walk(input logic [3:0] mode, input logic [1:0] pace,
                              input logic drain);
        int reads;
        reads = operand_reads(mode);
        add_req(make_start(mode, pick_pc(), pick_byte(), pick_byte()), pace, drain);
        useful_count++;
        for (int i = 0; i < reads; i++)
        begin
            if (chance(6))
                add_req(make_start(4'($urandom_range(0, 15)), pick_pc(), pick_byte(),
                                   pick_byte()), pace, 1'b0);
            add_req(make_byte(pick_byte()), pace, 1'b0);
            useful_count++;
        end
    endtask

    // Computes the result of one accepted request and advances the
    // testbench's copy of the sequencer state.
    task automatic step_address_sequencer(input eag_item_t req, output eag_result_t res);
        logic [3:0]  m;
        logic [7:0]  b;
        logic [7:0]  zp;
        logic [15:0] pc1;
        logic [15:0] pc2;
        logic [15:0] idx_base;
        logic [7:0]  idx_off;
        logic        use_index;
        logic        rd;
        logic [2:0]  nph;
        res = '0;
        b   = req.read_byte;
        if (req.kind == KIND_START)
        begin
            m = (req.mode > MODE_REL) ? MODE_IMP : req.mode;
            if (seq_state.busy)
                res.protocol_error = 1'b1;
            else if (m == MODE_IMP)
            begin
                res.done_res = 1'b1;
                res.next_pc  = req.pc_start;
            end
            else if (m == MODE_IMM)
            begin
                res.done_res = 1'b1;
                res.address  = req.pc_start;
                res.next_pc  = req.pc_start + 16'd1;
            end
            else
            begin
                seq_state.busy         = 1'b1;
                seq_state.mode_held    = m;
                seq_state.phase        = PH_FIRST;
                seq_state.pc_held      = req.pc_start;
                seq_state.x_held       = req.index_x;
                seq_state.y_held       = req.index_y;
                seq_state.operand_word = '0;
                seq_state.pointer_low  = '0;
                res.address            = req.pc_start;
            end
        end
        else if (!seq_state.busy)
            res.protocol_error = 1'b1;
        else
        begin
            pc1       = seq_state.pc_held + 16'd1;
            pc2       = seq_state.pc_held + 16'd2;
            rd        = 1'b0;
            nph       = PH_IDLE;
            use_index = 1'b0;
            idx_base  = '0;
            idx_off   = '0;
            // Anything that does not issue a read finishes; a byte in a phase the mode
            // never reaches finishes with every field but done_res zero.
            res.done_res = 1'b1;
            case (seq_state.mode_held) inside
                MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL:
                begin
                    if (seq_state.phase == PH_FIRST)
                    begin
                        zp = b;
                        if (seq_state.mode_held == MODE_ZPX)
                            zp = b + seq_state.x_held;
                        else if (seq_state.mode_held == MODE_ZPY)
                            zp = b + seq_state.y_held;
                        res.address = (seq_state.mode_held == MODE_REL) ?
                                      {{8{b[7]}}, b} : {8'h00, zp};
                        res.next_pc = pc1;
                    end
                end
                MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND:
                begin
                    if (seq_state.phase == PH_FIRST)
                    begin
                        seq_state.operand_word = {8'h00, b};
                        rd          = 1'b1;
                        nph         = PH_SECOND;
                        res.address = pc1;
                    end
                    else if (seq_state.phase == PH_SECOND)
                    begin
                        seq_state.operand_word = {b, seq_state.operand_word[7:0]};
                        res.next_pc = pc2;
                        if (seq_state.mode_held == MODE_IND)
                        begin
                            rd          = 1'b1;
                            nph         = PH_THIRD;
                            res.address = seq_state.operand_word;
                        end
                        else if (seq_state.mode_held == MODE_ABS)
                            res.address = seq_state.operand_word;
                        else
                        begin
                            use_index = 1'b1;
                            idx_base  = seq_state.operand_word;
                            idx_off   = (seq_state.mode_held == MODE_ABX) ?
                                        seq_state.x_held : seq_state.y_held;
                        end
                    end
                    else if (seq_state.mode_held == MODE_IND && seq_state.phase == PH_THIRD)
                    begin
                        // The pointer's high byte comes from the same page.
                        seq_state.pointer_low = b;
                        zp          = seq_state.operand_word[7:0] + 8'd1;
                        rd          = 1'b1;
                        nph         = PH_FOURTH;
                        res.address = {seq_state.operand_word[15:8], zp};
                    end
                    else if (seq_state.mode_held == MODE_IND && seq_state.phase == PH_FOURTH)
                    begin
                        res.address = {b, seq_state.pointer_low};
                        res.next_pc = pc2;
                    end
                end
                MODE_IZX, MODE_IZY:
                begin
                    if (seq_state.phase == PH_FIRST)
                    begin
                        zp = (seq_state.mode_held == MODE_IZX) ? b + seq_state.x_held : b;
                        seq_state.operand_word = {8'h00, zp};
                        rd          = 1'b1;
                        nph         = PH_SECOND;
                        res.address = seq_state.operand_word;
                    end
                    else if (seq_state.phase == PH_SECOND)
                    begin
                        seq_state.pointer_low = b;
                        zp          = seq_state.operand_word[7:0] + 8'd1;
                        rd          = 1'b1;
                        nph         = PH_THIRD;
                        res.address = {8'h00, zp};
                    end
                    else if (seq_state.phase == PH_THIRD)
                    begin
                        res.next_pc = pc1;
                        if (seq_state.mode_held == MODE_IZX)
                            res.address = {b, seq_state.pointer_low};
                        else
                        begin
                            use_index = 1'b1;
                            idx_base  = {b, seq_state.pointer_low};
                            idx_off   = seq_state.y_held;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (use_index)
            begin
                res.address      = idx_base + {8'h00, idx_off};
                res.page_crossed = (res.address[15:8] != idx_base[15:8]);
            end
            if (rd)
            begin
                res.done_res    = 1'b0;
                res.next_pc     = '0;
                seq_state.phase = nph;
            end
            else
            begin
                seq_state.busy  = 1'b0;
                seq_state.phase = PH_IDLE;
            end
        end
    endtask

    // Request driver. Inputs change on the falling edge. A request that was
    // not taken at the last rising edge stays on the bus unchanged; item_valid
    // gets exactly one assignment per edge so it never glitches between
    // back-to-back requests. A request marked for draining is held back until
    // every outstanding result has come out of the block.
    always @(negedge clk)
    begin
        queued_req_t head;
        logic        next_valid;
        next_valid = item_valid && !req_taken;
        if (rst_n && !next_valid && bus_requests.size() > 0)
        begin
            head = bus_requests[0];
            if (!(head.drain && addr_results_due.size() != 0) &&
                !chance(pause_pct(head.pace, 1'b0)))
            begin
                void'(bus_requests.pop_front());
                item       <= head.req;
                pace_now   <= head.pace;
                next_valid  = 1'b1;
            end
        end
        item_valid <= next_valid;
    end

    // Result stall, random under the pattern of the latest request driven.
    // It never looks at result_valid.
    always @(negedge clk)
    begin
        result_stall <= rst_n ? chance(pause_pct(pace_now, 1'b1)) : 1'b0;
    end

    // Monitor. Everything is sampled on the rising edge. The returning result
    // is checked before the newly accepted request is predicted, so a stray
    // result can never be matched against the prediction for this same edge.
    always @(posedge clk)
    begin
        eag_result_t want;
        eag_result_t predicted;
        if (rst_n)
        begin
            req_taken <= item_valid && !item_stall;
            if (result_valid && !result_stall)
            begin
                if (addr_results_due.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("result %0d with nothing awaited: %s",
                                 results_seen, show(result));
                    mismatches++;
                end
                else
                begin
                    want = addr_results_due.pop_front();
                    if (want.done_res       !== result.done_res     ||
                        want.address        !== result.address      ||
                        want.page_crossed   !== result.page_crossed ||
                        want.next_pc        !== result.next_pc      ||
                        want.protocol_error !== result.protocol_error)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("result %0d: expected %s, got %s",
                                     results_seen, show(want), show(result));
                        mismatches++;
                    end
                end
                results_seen++;
            end
            if (item_valid && !item_stall)
            begin
                step_address_sequencer(item, predicted);
                addr_results_due.push_back(predicted);
            end
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] pace;
        logic [1:0] last_pace;
        logic [3:0] mode;

        // Directed requests, all without idling.
        // Implied and immediate modes finish at once; immediate at the top of
        // memory wraps the next PC to zero. An undefined mode acts as implied.
        add_req(make_start(MODE_IMP, 16'hFFFF, 8'h00, 8'h00), PACE_FREE, 1'b0);
        add_req(make_start(MODE_IMM, 16'hFFFF, 8'hFF, 8'hFF), PACE_FREE, 1'b0);
        add_req(make_start(MODE_UNUSED_TOP, 16'h1234, 8'h55, 8'hAA), PACE_FREE, 1'b0);
        // A byte with no computation open is a protocol error.
        add_req(make_byte(8'hAA), PACE_FREE, 1'b0);
        // Zero page, and indexed zero page wrapping inside page zero.
        add_req(make_start(MODE_ZP, 16'h0000, 8'h00, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'hFF), PACE_FREE, 1'b0);
        add_req(make_start(MODE_ZPX, 16'h8000, 8'h20, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'hF0), PACE_FREE, 1'b0);
        add_req(make_start(MODE_ZPY, 16'h7FFF, 8'h00, 8'h01), PACE_FREE, 1'b0);
        add_req(make_byte(8'hFF), PACE_FREE, 1'b0);
        // Relative mode with the most negative offset.
        add_req(make_start(MODE_REL, 16'h4000, 8'h00, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'h80), PACE_FREE, 1'b0);
        // Absolute with the operand straddling the end of memory.
        add_req(make_start(MODE_ABS, 16'hFFFF, 8'h00, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'h34), PACE_FREE, 1'b0);
        add_req(make_byte(8'h12), PACE_FREE, 1'b0);
        // Indexed absolute, both crossing a page.
        add_req(make_start(MODE_ABX, 16'h0300, 8'hFF, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'h01), PACE_FREE, 1'b0);
        add_req(make_byte(8'h20), PACE_FREE, 1'b0);
        add_req(make_start(MODE_ABY, 16'h0400, 8'h00, 8'h10), PACE_FREE, 1'b0);
        add_req(make_byte(8'hF8), PACE_FREE, 1'b0);
        add_req(make_byte(8'h7F), PACE_FREE, 1'b0);
        // Indirect through a pointer on a page end, with a start arriving
        // while the computation is open.
        add_req(make_start(MODE_IND, 16'h0200, 8'h00, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'hFF), PACE_FREE, 1'b0);
        add_req(make_start(MODE_ABS, 16'hABCD, 8'h00, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'h12), PACE_FREE, 1'b0);
        add_req(make_byte(8'h78), PACE_FREE, 1'b0);
        add_req(make_byte(8'h56), PACE_FREE, 1'b0);
        // Indexed indirect with the pointer wrapping to address zero.
        add_req(make_start(MODE_IZX, 16'h0600, 8'h01, 8'h00), PACE_FREE, 1'b0);
        add_req(make_byte(8'hFF), PACE_FREE, 1'b0);
        add_req(make_byte(8'h34), PACE_FREE, 1'b0);
        add_req(make_byte(8'h12), PACE_FREE, 1'b0);
        // Indirect indexed: pointer at the end of page zero, page crossed.
        add_req(make_start(MODE_IZY, 16'h0700, 8'h00, 8'h80), PACE_FREE, 1'b0);
        add_req(make_byte(8'hFF), PACE_FREE, 1'b0);
        add_req(make_byte(8'hC0), PACE_FREE, 1'b0);
        add_req(make_byte(8'h30), PACE_FREE, 1'b0);

        // Random part: mostly complete computations with random content, a
        // few stray bytes while idle. The idling pattern cycles through free
        // running, slow sender, slow receiver and both slow; each change of
        // pattern first lets the block drain completely.
        useful_count = 0;
        last_pace    = PACE_FREE;
        while (useful_count < RANDOM_ITEMS)
        begin
            pace = 2'((useful_count / SEGMENT_LEN) % 4);
            if (chance(8))
                add_req(make_byte(pick_byte()), pace, 1'b0);
            mode = chance(90) ? 4'($urandom_range(MODE_IMP, MODE_REL)) :
                                4'($urandom_range(MODE_REL + 1, MODE_UNUSED_TOP));
            queue_walk(mode, pace, pace != last_pace);
            last_pace = pace;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last request to be taken and its result to return.
        while (bus_requests.size() != 0 || item_valid)
            @(posedge clk);
        while (addr_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
